// File: design/mi3_pkg.sv
package mi3_pkg;

  localparam int unsigned NUM_ELEM = 9;
  localparam int unsigned NUM_PROD = 18;

  typedef logic [3:0] idx_t;

  // cofactor k = m[PROD_A[2k]]*m[PROD_B[2k]] - m[PROD_A[2k+1]]*m[PROD_B[2k+1]]
  localparam idx_t PROD_A [NUM_PROD] = '{
    4'd4, 4'd5, 4'd5, 4'd3, 4'd3, 4'd4, 4'd2, 4'd1, 4'd0,
    4'd2, 4'd1, 4'd0, 4'd1, 4'd2, 4'd2, 4'd0, 4'd0, 4'd1
  };
  localparam idx_t PROD_B [NUM_PROD] = '{
    4'd8, 4'd7, 4'd6, 4'd8, 4'd7, 4'd6, 4'd7, 4'd8, 4'd8,
    4'd6, 4'd6, 4'd7, 4'd5, 4'd4, 4'd3, 4'd5, 4'd4, 4'd3
  };

  typedef struct packed {
    logic big;
    logic neg;
  } div_flag_t;

endpackage

// File: design/mi3_div.sv
module mi3_div #(
  parameter int W   = 32,
  parameter int NW  = 96,
  parameter int DMW = 98
) (
  input  logic                    clk,
  input  logic [NW-1:0]           num,
  input  logic [DMW-1:0]          den,
  input  logic                    neg_in,
  output logic [W-1:0]            q,
  output mi3_pkg::div_flag_t      flag
);

  localparam int XW = ((NW > DMW + W) ? NW : DMW + W) + 1;

  logic [NW-1:0]          rem [W];
  logic [DMW-1:0]         dn  [W];
  logic [W-1:0]           qa  [W+1];
  mi3_pkg::div_flag_t     fl  [W+1];

  // quotient of W bits or more saturates anyway
  always_ff @(posedge clk) begin
    rem[0]     <= num;
    dn[0]      <= den;
    qa[0]      <= '0;
    fl[0].big  <= XW'(num) >= (XW'(den) << W);
    fl[0].neg  <= neg_in;
  end

  for (genvar s = 1; s <= W; s++) begin : g_step
    localparam int K = W - s;
    logic [XW-1:0] sh;
    logic [XW-1:0] diff;
    logic          ge;

    always_comb begin
      sh   = XW'(dn[s-1]) << K;
      diff = XW'(rem[s-1]) - sh;
      ge   = ~diff[XW-1];
    end

    always_ff @(posedge clk) begin
      qa[s] <= qa[s-1] | (W'(ge) << K);
      fl[s] <= fl[s-1];
    end

    if (s < W) begin : g_carry
      always_ff @(posedge clk) begin
        rem[s] <= ge ? diff[NW-1:0] : rem[s-1];
        dn[s]  <= dn[s-1];
      end
    end
  end

  assign q    = qa[W];
  assign flag = fl[W];

endmodule

// File: design/mat3_inverse_core.sv
// 3x3 matrix inverse by the adjugate, signed fixed point (Q16.16 by default).
// Input: drive the nine elements in_r0c0..in_r2c2 and pulse start; a transfer
// happens at every rising edge with start high and busy low. busy is always
// low, so a new matrix may enter every cycle.
// Output: done is high for one cycle with inv_*, det_value, singular and
// overflow valid in that cycle only; the receiver cannot hold it off.
// Throughput: one matrix per cycle.
// Pipeline: products, cofactors, split determinant products, combine, sum,
// magnitudes, then one restoring divider per element with one quotient bit
// per stage (ELEM_WIDTH + 1 stages), then saturation and output registers.
// Quotients round toward zero and clamp, setting overflow. A zero
// determinant gives all-zero outputs with singular set.
// Reset: rst clears all valid bits; items in flight are dropped. Data
// registers are not reset.
module mat3_inverse_core #(
  parameter int ELEM_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [ELEM_WIDTH-1:0] in_r0c0,
  input  logic signed [ELEM_WIDTH-1:0] in_r0c1,
  input  logic signed [ELEM_WIDTH-1:0] in_r0c2,
  input  logic signed [ELEM_WIDTH-1:0] in_r1c0,
  input  logic signed [ELEM_WIDTH-1:0] in_r1c1,
  input  logic signed [ELEM_WIDTH-1:0] in_r1c2,
  input  logic signed [ELEM_WIDTH-1:0] in_r2c0,
  input  logic signed [ELEM_WIDTH-1:0] in_r2c1,
  input  logic signed [ELEM_WIDTH-1:0] in_r2c2,
  output logic                         done,
  output logic signed [ELEM_WIDTH-1:0] inv_r0c0,
  output logic signed [ELEM_WIDTH-1:0] inv_r0c1,
  output logic signed [ELEM_WIDTH-1:0] inv_r0c2,
  output logic signed [ELEM_WIDTH-1:0] inv_r1c0,
  output logic signed [ELEM_WIDTH-1:0] inv_r1c1,
  output logic signed [ELEM_WIDTH-1:0] inv_r1c2,
  output logic signed [ELEM_WIDTH-1:0] inv_r2c0,
  output logic signed [ELEM_WIDTH-1:0] inv_r2c1,
  output logic signed [ELEM_WIDTH-1:0] inv_r2c2,
  output logic signed [ELEM_WIDTH-1:0] det_value,
  output logic                         singular,
  output logic                         overflow
);

  localparam int W   = ELEM_WIDTH;
  localparam int PW  = 2 * W;
  localparam int CW  = 2 * W + 1;
  localparam int DW  = 3 * W + 3;
  localparam int DMW = DW - 1;
  localparam int NW  = 2 * W + 2 * FRAC_BITS;
  localparam int LD  = W + 1;
  localparam int LAT = W + 8;
  localparam int NE  = mi3_pkg::NUM_ELEM;
  localparam int NP  = mi3_pkg::NUM_PROD;

  localparam logic [W-1:0] LIM_POS = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] LIM_NEG = {1'b1, {(W-1){1'b0}}};

  logic signed [W-1:0] m_in [NE];

  assign m_in[0] = in_r0c0;
  assign m_in[1] = in_r0c1;
  assign m_in[2] = in_r0c2;
  assign m_in[3] = in_r1c0;
  assign m_in[4] = in_r1c1;
  assign m_in[5] = in_r1c2;
  assign m_in[6] = in_r2c0;
  assign m_in[7] = in_r2c1;
  assign m_in[8] = in_r2c2;

  assign busy = 1'b0;

  // valid chain
  logic s1_vld, s2_vld, s3_vld, s4_vld, s5_vld, s6_vld;
  logic dl_vld [LD];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
      s3_vld <= 1'b0;
      s4_vld <= 1'b0;
      s5_vld <= 1'b0;
      s6_vld <= 1'b0;
      for (int k = 0; k < LD; k++) dl_vld[k] <= 1'b0;
      done   <= 1'b0;
    end else begin
      s1_vld <= start & ~busy;
      s2_vld <= s1_vld;
      s3_vld <= s2_vld;
      s4_vld <= s3_vld;
      s5_vld <= s4_vld;
      s6_vld <= s5_vld;
      dl_vld[0] <= s6_vld;
      for (int k = 1; k < LD; k++) dl_vld[k] <= dl_vld[k-1];
      done   <= dl_vld[LD-1];
    end
  end

  // stage 1: minor products
  logic signed [PW-1:0] s1_p  [NP];
  logic signed [W-1:0]  s1_r0 [3];

  always_ff @(posedge clk) begin
    for (int k = 0; k < NP; k++)
      s1_p[k] <= m_in[mi3_pkg::PROD_A[k]] * m_in[mi3_pkg::PROD_B[k]];
    for (int j = 0; j < 3; j++) s1_r0[j] <= m_in[j];
  end

  // stage 2: cofactors
  logic signed [CW-1:0] s2_cof [NE];
  logic signed [W-1:0]  s2_r0  [3];

  always_ff @(posedge clk) begin
    for (int k = 0; k < NE; k++)
      s2_cof[k] <= CW'(s1_p[2*k]) - CW'(s1_p[2*k+1]);
    s2_r0 <= s1_r0;
  end

  // stage 3: row 0 times cofactor, split in two partial products
  logic signed [CW-1:0] s3_pl  [3];
  logic signed [CW-1:0] s3_ph  [3];
  logic signed [CW-1:0] s3_cof [NE];

  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      s3_pl[j] <= s2_r0[j] * $signed({1'b0, s2_cof[j][W-1:0]});
      s3_ph[j] <= s2_r0[j] * $signed(s2_cof[j][CW-1:W]);
    end
    s3_cof <= s2_cof;
  end

  // stage 4: combine partial products
  logic signed [DW-1:0] s4_dp  [3];
  logic signed [CW-1:0] s4_cof [NE];

  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++)
      s4_dp[j] <= (DW'(s3_ph[j]) <<< W) + DW'(s3_pl[j]);
    s4_cof <= s3_cof;
  end

  // stage 5: determinant
  logic signed [DW-1:0] s5_det;
  logic signed [CW-1:0] s5_cof [NE];

  always_ff @(posedge clk) begin
    s5_det <= s4_dp[0] + s4_dp[1] + s4_dp[2];
    s5_cof <= s4_cof;
  end

  // stage 6: magnitudes, signs, det_value
  logic [DW-1:0]  det_abs;
  logic [DMW-1:0] det_sh;
  logic [DMW-1:0] dv_mag;
  logic           dv_neg;
  logic           dv_sat;
  logic [CW-1:0]  cof_abs [NE];

  logic [NW-1:0]  s6_num [NE];
  logic           s6_neg [NE];
  logic [DMW-1:0] s6_den;
  logic [W-1:0]   s6_dv;
  logic           s6_dvovf;
  logic           s6_sing;

  always_comb begin
    det_abs = s5_det[DW-1] ? DW'(-s5_det) : DW'(s5_det);
    det_sh  = det_abs[DMW-1:0] >> (2 * FRAC_BITS);
    dv_neg  = s5_det[DW-1] && (det_sh != '0);
    dv_sat  = det_sh > (dv_neg ? DMW'(LIM_NEG) : DMW'(LIM_POS));
    dv_mag  = dv_sat ? (dv_neg ? DMW'(LIM_NEG) : DMW'(LIM_POS)) : det_sh;
    for (int k = 0; k < NE; k++)
      cof_abs[k] = s5_cof[k][CW-1] ? CW'(-s5_cof[k]) : CW'(s5_cof[k]);
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        s6_num[i*3+j] <= {cof_abs[j*3+i][PW-1:0], {(2*FRAC_BITS){1'b0}}};
        s6_neg[i*3+j] <= s5_cof[j*3+i][CW-1] ^ s5_det[DW-1];
      end
    end
    s6_den   <= det_abs[DMW-1:0];
    s6_dv    <= dv_neg ? W'(-dv_mag) : dv_mag[W-1:0];
    s6_dvovf <= dv_sat;
    s6_sing  <= (s5_det == '0);
  end

  // dividers
  logic [W-1:0]       dq   [NE];
  mi3_pkg::div_flag_t dflg [NE];

  for (genvar n = 0; n < NE; n++) begin : g_div
    mi3_div #(
      .W   (W),
      .NW  (NW),
      .DMW (DMW)
    ) u_div (
      .clk    (clk),
      .num    (s6_num[n]),
      .den    (s6_den),
      .neg_in (s6_neg[n]),
      .q      (dq[n]),
      .flag   (dflg[n])
    );
  end

  // side data alongside the dividers
  logic [W-1:0] dl_dv    [LD];
  logic         dl_dvovf [LD];
  logic         dl_sing  [LD];

  always_ff @(posedge clk) begin
    dl_dv[0]    <= s6_dv;
    dl_dvovf[0] <= s6_dvovf;
    dl_sing[0]  <= s6_sing;
    for (int k = 1; k < LD; k++) begin
      dl_dv[k]    <= dl_dv[k-1];
      dl_dvovf[k] <= dl_dvovf[k-1];
      dl_sing[k]  <= dl_sing[k-1];
    end
  end

  // output stage: sign, clamp, singular
  logic [W-1:0] q_out [NE];
  logic [W-1:0] inv_next [NE];
  logic         q_neg  [NE];
  logic         q_sat  [NE];
  logic         any_sat;
  logic [W-1:0] inv_q [NE];

  always_comb begin
    any_sat = 1'b0;
    for (int k = 0; k < NE; k++) begin
      q_neg[k] = dflg[k].neg && (dflg[k].big || (dq[k] != '0));
      q_sat[k] = dflg[k].big || (dq[k] > (q_neg[k] ? LIM_NEG : LIM_POS));
      q_out[k] = q_sat[k] ? (q_neg[k] ? LIM_NEG : LIM_POS) : dq[k];
      inv_next[k] = dl_sing[LD-1] ? '0 : (q_neg[k] ? W'(-q_out[k]) : q_out[k]);
      any_sat = any_sat | q_sat[k];
    end
  end

  always_ff @(posedge clk) begin
    inv_q     <= inv_next;
    det_value <= dl_dv[LD-1];
    singular  <= dl_sing[LD-1];
    overflow  <= ~dl_sing[LD-1] & (any_sat | dl_dvovf[LD-1]);
  end

  assign inv_r0c0 = inv_q[0];
  assign inv_r0c1 = inv_q[1];
  assign inv_r0c2 = inv_q[2];
  assign inv_r1c0 = inv_q[3];
  assign inv_r1c1 = inv_q[4];
  assign inv_r1c2 = inv_q[5];
  assign inv_r2c0 = inv_q[6];
  assign inv_r2c1 = inv_q[7];
  assign inv_r2c2 = inv_q[8];

  a_latency : assert property (@(posedge clk) disable iff (rst)
    start |-> ##LAT done) else $error("transfer did not complete after fixed latency");

  a_no_orphan : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LAT)) else $error("result without a transfer");

  a_singular_zero : assert property (@(posedge clk) disable iff (rst)
    (done && singular) |-> (!overflow && det_value == '0 && inv_r1c1 == '0))
    else $error("singular result not cleared");

endmodule

// File: tb/sv/mat3_inverse_checker.sv
module mat3_inverse_checker (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             busy,
  input  logic [8:0][31:0] mat,
  input  logic             done,
  input  logic [8:0][31:0] inv,
  input  logic [31:0]      det_value,
  input  logic             singular,
  input  logic             overflow,
  output int               fail_count,
  output int               pending,
  output int               checked,
  output int               singular_seen,
  output int               overflow_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [159:0] wide_t;

  typedef struct {
    logic signed [31:0] inv [9];
    logic signed [31:0] det;
    logic               sing;
    logic               ovf;
  } inverse_t;

  localparam wide_t POS_MAX = 160'sd2147483647;
  localparam wide_t NEG_MAX = -160'sd2147483648;

  inverse_t expected_q[$];

  function automatic logic signed [31:0] clamp32(input wide_t v, inout logic ovf);
    if (v > POS_MAX) begin
      ovf = 1'b1;
      return POS_MAX[31:0];
    end
    if (v < NEG_MAX) begin
      ovf = 1'b1;
      return NEG_MAX[31:0];
    end
    return v[31:0];
  endfunction

  function automatic inverse_t invert3(input logic [8:0][31:0] m);
    inverse_t r;
    wide_t    e [9];
    wide_t    cof [9];
    wide_t    det;
    wide_t    minor;
    int       r0, r1, c0, c1;
    logic     ovf;
    for (int k = 0; k < 9; k++) e[k] = wide_t'($signed(m[k]));
    for (int i = 0; i < 3; i++) begin
      r0 = (i == 0) ? 1 : 0;
      r1 = (i == 2) ? 1 : 2;
      for (int j = 0; j < 3; j++) begin
        c0 = (j == 0) ? 1 : 0;
        c1 = (j == 2) ? 1 : 2;
        minor = e[r0*3+c0] * e[r1*3+c1] - e[r0*3+c1] * e[r1*3+c0];
        cof[i*3+j] = ((i + j) % 2 == 1) ? -minor : minor;
      end
    end
    det = e[0]*cof[0] + e[1]*cof[1] + e[2]*cof[2];
    ovf = 1'b0;
    if (det == 0) begin
      for (int k = 0; k < 9; k++) r.inv[k] = '0;
      r.det  = '0;
      r.sing = 1'b1;
      r.ovf  = 1'b0;
      return r;
    end
    // transposed cofactor over det, truncated toward zero
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        r.inv[i*3+j] = clamp32((cof[j*3+i] <<< 32) / det, ovf);
    r.det  = clamp32(det / (wide_t'(1) <<< 32), ovf);
    r.sing = 1'b0;
    r.ovf  = ovf;
    return r;
  endfunction

  always @(posedge clk) begin
    inverse_t exp_r;
    logic     bad;
    if (rst) begin
      expected_q.delete();
    end else begin
      if (start && !busy) expected_q.push_back(invert3(mat));
      if (done) begin
        if (expected_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result transfer at %0t", $realtime);
        end else begin
          exp_r = expected_q.pop_front();
          bad = (exp_r.det !== det_value) || (exp_r.sing !== singular) ||
                (exp_r.ovf !== overflow);
          for (int k = 0; k < 9; k++) if (exp_r.inv[k] !== inv[k]) bad = 1'b1;
          checked++;
          if (singular) singular_seen++;
          if (overflow) overflow_seen++;
          if (bad) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("mismatch at %0t: det exp %h got %h, sing exp %b got %b, ovf exp %b got %b",
                       $realtime, exp_r.det, det_value, exp_r.sing, singular, exp_r.ovf, overflow);
              for (int k = 0; k < 9; k++)
                $display("  inv[%0d] exp %h got %h", k, exp_r.inv[k], inv[k]);
            end
          end
        end
      end
    end
    pending = expected_q.size();
  end

  initial begin
    fail_count    = 0;
    pending       = 0;
    checked       = 0;
    singular_seen = 0;
    overflow_seen = 0;
  end
endmodule

// File: tb/sv/mat3_inverse_core_tb.sv
module mat3_inverse_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_RANDOM = 1730;
  localparam int CYCLE_LIMIT = 400000;

  logic             clk;
  logic             rst;
  logic             start;
  logic             busy;
  logic             done;
  logic [8:0][31:0] mat;
  logic [8:0][31:0] inv;
  logic [31:0]      det_value;
  logic             singular;
  logic             overflow;
  int               fail_count, pending, checked, singular_seen, overflow_seen;
  int               cycles;
  int               sent;

  mat3_inverse_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .in_r0c0(mat[0]), .in_r0c1(mat[1]), .in_r0c2(mat[2]),
    .in_r1c0(mat[3]), .in_r1c1(mat[4]), .in_r1c2(mat[5]),
    .in_r2c0(mat[6]), .in_r2c1(mat[7]), .in_r2c2(mat[8]),
    .done(done),
    .inv_r0c0(inv[0]), .inv_r0c1(inv[1]), .inv_r0c2(inv[2]),
    .inv_r1c0(inv[3]), .inv_r1c1(inv[4]), .inv_r1c2(inv[5]),
    .inv_r2c0(inv[6]), .inv_r2c1(inv[7]), .inv_r2c2(inv[8]),
    .det_value(det_value), .singular(singular), .overflow(overflow)
  );

  mat3_inverse_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .mat(mat),
    .done(done), .inv(inv), .det_value(det_value), .singular(singular),
    .overflow(overflow), .fail_count(fail_count), .pending(pending),
    .checked(checked), .singular_seen(singular_seen), .overflow_seen(overflow_seen)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // one transfer; may idle first when asked
  task automatic transfer(input logic [8:0][31:0] m, input bit may_idle);
    while (may_idle && $urandom_range(99) < 20) begin
      start = 1'b0;
      @(negedge clk);
    end
    mat   = m;
    start = 1'b1;
    do @(posedge clk); while (busy);
    sent++;
    @(negedge clk);
    start = 1'b0;
  endtask

  function automatic logic [31:0] q16(input int whole);
    return 32'(whole) << 16;
  endfunction

  function automatic logic [31:0] elem(input int style);
    case (style)
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      2: return 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17)) << $urandom_range(0, 12);
      default: return 32'($signed($urandom_range(0, 16)) - 8);
    endcase
  endfunction

  function automatic logic [8:0][31:0] rand_matrix();
    logic [8:0][31:0] m;
    int style, kind;
    style = $urandom_range(0, 3);
    kind  = $urandom_range(0, 9);
    for (int k = 0; k < 9; k++) m[k] = elem(style);
    if (kind < 4) begin
      // diagonal boosted; dominant only when the other elements are small
      m[0] = m[0] + q16($urandom_range(1, 200));
      m[4] = m[4] - q16($urandom_range(1, 200));
      m[8] = m[8] + q16($urandom_range(1, 200));
    end else if (kind == 4) begin
      m[6] = m[0]; m[7] = m[1]; m[8] = m[2];
    end else if (kind == 5) begin
      for (int r = 0; r < 3; r++) m[r*3+2] = m[r*3] << 1;
    end
    return m;
  endfunction

  initial begin
    logic [8:0][31:0] m;
    cycles = 0;
    sent   = 0;
    start  = 1'b0;
    mat    = '0;
    rst    = 1'b1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    m = '0; m[0] = q16(1); m[4] = q16(1); m[8] = q16(1);
    transfer(m, 0);
    m = '0;
    transfer(m, 0);
    m = '0; m[0] = q16(2); m[4] = q16(-4); m[8] = 32'h0000_8000;
    transfer(m, 0);
    // tiny determinant: det_value rounds to zero, inverse saturates
    m = '0; m[0] = 32'd1; m[4] = 32'd1; m[8] = 32'd1;
    transfer(m, 0);
    m = '0; m[0] = 32'hFFFF_FFFF; m[4] = 32'd1; m[8] = 32'd1;
    transfer(m, 0);
    for (int k = 0; k < 9; k++) m[k] = 32'h7FFF_FFFF;
    transfer(m, 0);
    for (int k = 0; k < 9; k++) m[k] = 32'h8000_0000;
    transfer(m, 0);
    m = '0; m[0] = 32'h7FFF_FFFF; m[4] = 32'h7FFF_FFFF; m[8] = 32'h7FFF_FFFF;
    transfer(m, 0);
    m = '0; m[0] = 32'h8000_0000; m[4] = 32'h8000_0000; m[8] = 32'h8000_0000;
    transfer(m, 0);
    m = '0; m[2] = 32'h8000_0000; m[4] = 32'h7FFF_FFFF; m[6] = 32'h8000_0000;
    transfer(m, 0);
    m = '0; m[1] = q16(1); m[3] = q16(1); m[8] = q16(-1);
    transfer(m, 0);
    m = '0; m[0] = q16(1); m[1] = q16(2); m[2] = q16(3);
    m[3] = q16(4); m[4] = q16(5); m[5] = q16(6);
    m[6] = q16(7); m[7] = q16(8); m[8] = q16(10);
    transfer(m, 0);
    m[8] = q16(9);
    transfer(m, 0);
    m = '0; m[0] = 32'h0000_0100; m[4] = 32'h0000_0100; m[8] = 32'h0100_0000;
    transfer(m, 0);
    for (int k = 0; k < 9; k++) m[k] = $urandom;
    transfer(m, 0);

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == 1000) begin
        start = 1'b0;
        wait (pending == 0);
        @(negedge clk);
      end
      transfer(rand_matrix(), !(n >= 500 && n < 800));
    end
    start = 1'b0;

    wait (pending == 0);
    repeat (60) @(posedge clk);
    $display("%0d matrices sent, %0d results checked (%0d singular, %0d saturated)",
             sent, checked, singular_seen, overflow_seen);
    $display("mix of full-range, mid-range, small and dependent-row matrices, back to back and gapped");
    if (fail_count == 0 && pending == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end
endmodule
